// ----- rtl/mjst_pkg.sv -----
// ----------------------------------------------------------------------------
// Minimum-jerk swing trajectory package
// Shared widths, latencies, register codes and fixed-point helpers.
// ----------------------------------------------------------------------------
package mjst_pkg;

  localparam int FRAC_BITS = 16;
  localparam int ONE_W     = FRAC_BITS + 1;          // holds 0..ONE
  localparam logic [ONE_W-1:0] ONE = ONE_W'(1) << FRAC_BITS;

  localparam int DATA_W   = 32;
  localparam int DUR_W    = 31;
  localparam int DP_W     = DATA_W + 2;              // end - start, signed
  localparam int COEF_W   = 32;                      // basis coefficients
  localparam int WIDE_W   = 48;                      // scaled terms and sums
  localparam int QUO_W    = 40;                      // rate magnitude cap 2^40
  localparam int RES_W    = QUO_W + 2;               // signed capped quotient

  localparam int NUM_REGS = 8;
  localparam int ADDR_W   = $clog2(NUM_REGS) + 2;

  localparam int AXES      = 3;
  localparam int AXIS_Z    = 2;
  localparam int NLANE     = AXES + 1;               // three axes plus bump
  localparam int LANE_BUMP = AXES;

  localparam int PH_LAT   = FRAC_BITS;
  localparam int POLY_LAT = 5;
  localparam int DIV_LAT  = QUO_W;
  localparam int TOT_LAT  = PH_LAT + POLY_LAT + 1 + 2 * DIV_LAT;

  typedef enum logic [ADDR_W-3:0] {
    REG_START_X        = 3'd0,
    REG_START_Y        = 3'd1,
    REG_START_Z        = 3'd2,
    REG_END_X          = 3'd3,
    REG_END_Y          = 3'd4,
    REG_END_Z          = 3'd5,
    REG_SWING_DURATION = 3'd6,
    REG_BUMP_HEIGHT    = 3'd7
  } reg_idx_t;

  typedef logic signed [COEF_W-1:0] coef_t;

  // Basis terms of the quintic and of the height bump
  typedef struct packed {
    coef_t mj;
    coef_t dmj;
    coef_t d2mj;
    coef_t b;
    coef_t db;
    coef_t d2b;
  } basis_t;

  // a*b / ONE, truncated toward zero
  function automatic logic signed [WIDE_W-1:0] mulq(input logic signed [DP_W-1:0] a,
                                                    input coef_t b);
    logic [DP_W-1:0]          ma;
    logic [COEF_W-1:0]        mb;
    logic [DP_W+COEF_W-1:0]   p;
    logic [WIDE_W-1:0]        r;
    ma = a[DP_W-1] ? DP_W'(-a) : DP_W'(a);
    mb = b[COEF_W-1] ? COEF_W'(-b) : COEF_W'(b);
    p  = ma * mb;
    r  = WIDE_W'(p >> FRAC_BITS);
    return (a[DP_W-1] ^ b[COEF_W-1]) ? -$signed(r) : $signed(r);
  endfunction

  // Clip a wide signed value to the 32-bit signed range
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    hi = {{(WIDE_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
    lo = {{(WIDE_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};
    if (v > hi) begin
      return hi[DATA_W-1:0];
    end else if (v < lo) begin
      return lo[DATA_W-1:0];
    end
    return v[DATA_W-1:0];
  endfunction

endpackage

// ----- rtl/mjst_phase.sv -----
// ----------------------------------------------------------------------------
// Phase divider
// Clamps the query time to 0..T and forms s = t*ONE/T, one bit per stage.
// ----------------------------------------------------------------------------
module mjst_phase import mjst_pkg::*; (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [DATA_W-1:0] t,
  input  logic [DUR_W-1:0]         dur,
  output logic [ONE_W-1:0]         s
);

  logic                  lo_c;
  logic                  hi_c;
  logic [DUR_W-1:0]      rem0_c;

  logic [DUR_W-1:0]      rem_r   [PH_LAT];
  logic [FRAC_BITS-1:0]  q_r     [PH_LAT];
  logic                  lo_r    [PH_LAT];
  logic                  hi_r    [PH_LAT];
  logic [DUR_W-1:0]      rem_nxt [PH_LAT];
  logic [FRAC_BITS-1:0]  q_nxt   [PH_LAT];
  logic [DUR_W-1:0]      rem_src [PH_LAT];
  logic [FRAC_BITS-1:0]  q_src   [PH_LAT];
  logic                  lo_src  [PH_LAT];
  logic                  hi_src  [PH_LAT];
  logic [DUR_W:0]        shf     [PH_LAT];

  // Clamp: before start gives zero, at or past the end gives ONE
  always_comb begin
    lo_c   = t[DATA_W-1] || (t == '0);
    hi_c   = !lo_c && (t[DUR_W-1:0] >= dur);
    rem0_c = (lo_c || hi_c) ? '0 : t[DUR_W-1:0];
  end

  // One restoring step per stage
  always_comb begin
    rem_src[0] = rem0_c;
    q_src[0]   = '0;
    lo_src[0]  = lo_c;
    hi_src[0]  = hi_c;
    for (int k = 1; k < PH_LAT; k++) begin
      rem_src[k] = rem_r[k-1];
      q_src[k]   = q_r[k-1];
      lo_src[k]  = lo_r[k-1];
      hi_src[k]  = hi_r[k-1];
    end
    for (int k = 0; k < PH_LAT; k++) begin
      shf[k] = {rem_src[k], 1'b0};
      if (shf[k] >= {1'b0, dur}) begin
        rem_nxt[k] = DUR_W'(shf[k] - {1'b0, dur});
        q_nxt[k]   = {q_src[k][FRAC_BITS-2:0], 1'b1};
      end else begin
        rem_nxt[k] = shf[k][DUR_W-1:0];
        q_nxt[k]   = {q_src[k][FRAC_BITS-2:0], 1'b0};
      end
    end
  end

  // Advance all stages together
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < PH_LAT; k++) begin
        rem_r[k] <= rem_nxt[k];
        q_r[k]   <= q_nxt[k];
        lo_r[k]  <= lo_src[k];
        hi_r[k]  <= hi_src[k];
      end
    end
  end

  assign s = lo_r[PH_LAT-1] ? '0 :
             hi_r[PH_LAT-1] ? ONE : {1'b0, q_r[PH_LAT-1]};

endmodule

// ----- rtl/mjst_poly.sv -----
// ----------------------------------------------------------------------------
// Basis polynomial pipeline
// Powers of s and 1-s, then the quintic and bump terms, over five stages.
// ----------------------------------------------------------------------------
module mjst_poly import mjst_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [ONE_W-1:0] s,
  output basis_t           bas
);

  typedef logic [ONE_W-1:0]      frac_t;
  typedef logic signed [ONE_W:0] sfrac_t;

  function automatic frac_t um(input frac_t a, input frac_t b);
    logic [2*ONE_W-1:0] p;
    p = a * b;
    return frac_t'(p >> FRAC_BITS);
  endfunction

  function automatic sfrac_t sm(input frac_t a, input sfrac_t w);
    frac_t mw;
    frac_t p;
    mw = w[ONE_W] ? frac_t'(-w) : frac_t'(w);
    p  = um(a, mw);
    return w[ONE_W] ? -sfrac_t'(p) : sfrac_t'(p);
  endfunction

  frac_t  u_c;
  sfrac_t w_c;

  frac_t  p1_s_r, p1_u_r, p1_s2_r, p1_u2_r;
  sfrac_t p1_w_r;
  frac_t  p2_s_r, p2_s2_r, p2_s3_r, p2_u3_r, p2_s2u2_r, p2_su2_r, p2_s2u_r;
  sfrac_t p2_w_r;
  frac_t  p3_s_r, p3_s2_r, p3_s3_r, p3_s4_r, p3_s2u2_r, p3_s3u3_r;
  sfrac_t p3_a_r, p3_b_r, p3_c_r;
  frac_t  p4_s3_r, p4_s4_r, p4_s5_r;
  coef_t  p4_dmj_r, p4_d2mj_r, p4_b_r, p4_db_r, p4_d2b_r;
  basis_t bas_r;

  assign u_c = ONE - s;
  assign w_c = sfrac_t'({1'b0, ONE} - {s, 1'b0});

  // Stage 1: squares
  always_ff @(posedge clk) begin
    if (en) begin
      p1_s_r  <= s;
      p1_u_r  <= u_c;
      p1_w_r  <= w_c;
      p1_s2_r <= um(s, s);
      p1_u2_r <= um(u_c, u_c);
    end
  end

  // Stage 2: cubes and mixed products
  always_ff @(posedge clk) begin
    if (en) begin
      p2_s_r    <= p1_s_r;
      p2_w_r    <= p1_w_r;
      p2_s2_r   <= p1_s2_r;
      p2_s3_r   <= um(p1_s2_r, p1_s_r);
      p2_u3_r   <= um(p1_u2_r, p1_u_r);
      p2_s2u2_r <= um(p1_s2_r, p1_u2_r);
      p2_su2_r  <= um(p1_s_r, p1_u2_r);
      p2_s2u_r  <= um(p1_s2_r, p1_u_r);
    end
  end

  // Stage 3: fourth power, bump core and products with 1-2s
  always_ff @(posedge clk) begin
    if (en) begin
      p3_s_r    <= p2_s_r;
      p3_s2_r   <= p2_s2_r;
      p3_s3_r   <= p2_s3_r;
      p3_s2u2_r <= p2_s2u2_r;
      p3_s4_r   <= um(p2_s3_r, p2_s_r);
      p3_s3u3_r <= um(p2_s3_r, p2_u3_r);
      p3_a_r    <= sm(p2_s2u2_r, p2_w_r);
      p3_b_r    <= sm(p2_su2_r, p2_w_r);
      p3_c_r    <= sm(p2_s2u_r, p2_w_r);
    end
  end

  // Stage 4: fifth power and derivative combinations
  always_ff @(posedge clk) begin
    if (en) begin
      p4_s3_r   <= p3_s3_r;
      p4_s4_r   <= p3_s4_r;
      p4_s5_r   <= um(p3_s4_r, p3_s_r);
      p4_dmj_r  <= 32'sd30 * coef_t'(p3_s2_r) - 32'sd60 * coef_t'(p3_s3_r)
                 + 32'sd30 * coef_t'(p3_s4_r);
      p4_d2mj_r <= 32'sd60 * coef_t'(p3_s_r) - 32'sd180 * coef_t'(p3_s2_r)
                 + 32'sd120 * coef_t'(p3_s3_r);
      p4_b_r    <= 32'sd64 * coef_t'(p3_s3u3_r);
      p4_db_r   <= 32'sd192 * coef_t'(p3_a_r);
      p4_d2b_r  <= 32'sd192 * (32'sd2 * coef_t'(p3_b_r) - 32'sd2 * coef_t'(p3_c_r)
                 - 32'sd2 * coef_t'(p3_s2u2_r));
    end
  end

  // Stage 5: position blend
  always_ff @(posedge clk) begin
    if (en) begin
      bas_r.mj   <= 32'sd10 * coef_t'(p4_s3_r) - 32'sd15 * coef_t'(p4_s4_r)
                  + 32'sd6 * coef_t'(p4_s5_r);
      bas_r.dmj  <= p4_dmj_r;
      bas_r.d2mj <= p4_d2mj_r;
      bas_r.b    <= p4_b_r;
      bas_r.db   <= p4_db_r;
      bas_r.d2b  <= p4_d2b_r;
    end
  end

  assign bas = bas_r;

endmodule

// ----- rtl/mjst_qdiv.sv -----
// ----------------------------------------------------------------------------
// Rate divider
// Pipelined x*ONE/T, truncated toward zero, magnitude capped at 2^40.
// ----------------------------------------------------------------------------
module mjst_qdiv import mjst_pkg::*; (
  input  logic                     clk,
  input  logic                     en,
  input  logic [DUR_W-1:0]         dur,
  input  logic signed [WIDE_W-1:0] x,
  output logic signed [RES_W-1:0]  q
);

  localparam int SH = QUO_W - FRAC_BITS;

  logic [WIDE_W-1:0] mx_c;
  logic [WIDE_W-1:0] hi_c;
  logic              ovf_c;

  logic [DUR_W-1:0]  rem_r   [DIV_LAT];
  logic [QUO_W-1:0]  fq_r    [DIV_LAT];
  logic              neg_r   [DIV_LAT];
  logic              ovf_r   [DIV_LAT];
  logic [DUR_W-1:0]  rem_nxt [DIV_LAT];
  logic [QUO_W-1:0]  fq_nxt  [DIV_LAT];
  logic [DUR_W-1:0]  rem_src [DIV_LAT];
  logic [QUO_W-1:0]  fq_src  [DIV_LAT];
  logic              neg_src [DIV_LAT];
  logic              ovf_src [DIV_LAT];
  logic [DUR_W:0]    shf     [DIV_LAT];
  logic [QUO_W:0]    mag_c;

  // Overflow when the quotient reaches the cap
  always_comb begin
    mx_c  = x[WIDE_W-1] ? WIDE_W'(-x) : WIDE_W'(x);
    hi_c  = mx_c >> SH;
    ovf_c = hi_c >= WIDE_W'(dur);
  end

  // Dividend low bits shift out as quotient bits shift in
  always_comb begin
    rem_src[0] = ovf_c ? '0 : hi_c[DUR_W-1:0];
    fq_src[0]  = {mx_c[SH-1:0], {FRAC_BITS{1'b0}}};
    neg_src[0] = x[WIDE_W-1];
    ovf_src[0] = ovf_c;
    for (int k = 1; k < DIV_LAT; k++) begin
      rem_src[k] = rem_r[k-1];
      fq_src[k]  = fq_r[k-1];
      neg_src[k] = neg_r[k-1];
      ovf_src[k] = ovf_r[k-1];
    end
    for (int k = 0; k < DIV_LAT; k++) begin
      shf[k] = {rem_src[k], fq_src[k][QUO_W-1]};
      if (shf[k] >= {1'b0, dur}) begin
        rem_nxt[k] = DUR_W'(shf[k] - {1'b0, dur});
        fq_nxt[k]  = {fq_src[k][QUO_W-2:0], 1'b1};
      end else begin
        rem_nxt[k] = shf[k][DUR_W-1:0];
        fq_nxt[k]  = {fq_src[k][QUO_W-2:0], 1'b0};
      end
    end
  end

  // Advance all stages together
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < DIV_LAT; k++) begin
        rem_r[k] <= rem_nxt[k];
        fq_r[k]  <= fq_nxt[k];
        neg_r[k] <= neg_src[k];
        ovf_r[k] <= ovf_src[k];
      end
    end
  end

  // Apply cap and sign
  always_comb begin
    mag_c = ovf_r[DIV_LAT-1] ? ((QUO_W+1)'(1) << QUO_W) : {1'b0, fq_r[DIV_LAT-1]};
    q     = neg_r[DIV_LAT-1] ? -$signed({1'b0, mag_c}) : $signed({1'b0, mag_c});
  end

endmodule

// ----- rtl/min_jerk_swing_trajectory_top.sv -----
// ----------------------------------------------------------------------------
// Minimum-jerk swing trajectory evaluator
// Position, velocity and acceleration on three axes from one query time.
//
//   channel   direction  transaction
//   in_*      input      query_time, Q16.16 seconds
//   out_*     output     pos/vel/acc on x, y, z, Q16.16, saturated
//   APB       config     start, end, swing_duration, bump_height
//
// One transaction enters per cycle unless the output stalls; the path to
// out_valid runs through 16 phase divider stages, 5 basis stages, 1 scaling
// stage, two 40-stage rate dividers in series and one output register.
// Reset clears the registers to zero and empties the pipeline.
// A stall on the output freezes every stage at once; nothing is lost.
// ----------------------------------------------------------------------------
module min_jerk_swing_trajectory_top import mjst_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [DATA_W-1:0] in_query_time,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] out_pos_x,
  output logic signed [DATA_W-1:0] out_pos_y,
  output logic signed [DATA_W-1:0] out_pos_z,
  output logic signed [DATA_W-1:0] out_vel_x,
  output logic signed [DATA_W-1:0] out_vel_y,
  output logic signed [DATA_W-1:0] out_vel_z,
  output logic signed [DATA_W-1:0] out_acc_x,
  output logic signed [DATA_W-1:0] out_acc_y,
  output logic signed [DATA_W-1:0] out_acc_z,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ADDR_W-1:0]        paddr,
  input  logic [DATA_W-1:0]        pwdata,
  output logic [DATA_W-1:0]        prdata,
  output logic                     pready
);

  localparam int PD = 2 * DIV_LAT;

  logic signed [DATA_W-1:0] start_r [AXES];
  logic signed [DATA_W-1:0] end_r   [AXES];
  logic [DUR_W-1:0]         dur_r;
  logic signed [DATA_W-1:0] height_r;

  logic                     cfg_wr;
  logic                     en;
  logic                     vld_r [TOT_LAT];
  logic                     out_vld_r;

  logic [ONE_W-1:0]         phase_s;
  basis_t                   bas;
  logic signed [DP_W-1:0]   dp [AXES];
  logic signed [DP_W-1:0]   h;

  logic signed [WIDE_W-1:0] pm_r [NLANE];
  logic signed [WIDE_W-1:0] vm_r [NLANE];
  logic signed [WIDE_W-1:0] am_r [NLANE];
  logic signed [RES_W-1:0]  vq   [NLANE];
  logic signed [RES_W-1:0]  aq1  [NLANE];
  logic signed [WIDE_W-1:0] aq1_w [NLANE];
  logic signed [RES_W-1:0]  aq2  [NLANE];

  logic signed [WIDE_W-1:0] pdly_r [NLANE][PD];
  logic signed [RES_W-1:0]  vdly_r [NLANE][DIV_LAT];

  logic signed [WIDE_W-1:0] pos_sum [AXES];
  logic signed [WIDE_W-1:0] vel_sum [AXES];
  logic signed [WIDE_W-1:0] acc_sum [AXES];

  logic signed [DATA_W-1:0] opos_r [AXES];
  logic signed [DATA_W-1:0] ovel_r [AXES];
  logic signed [DATA_W-1:0] oacc_r [AXES];

  // Configuration writes
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < AXES; k++) begin
        start_r[k] <= '0;
        end_r[k]   <= '0;
      end
      dur_r    <= '0;
      height_r <= '0;
    end else if (cfg_wr) begin
      case (reg_idx_t'(paddr[ADDR_W-1:2]))
        REG_START_X:        start_r[0] <= pwdata;
        REG_START_Y:        start_r[1] <= pwdata;
        REG_START_Z:        start_r[2] <= pwdata;
        REG_END_X:          end_r[0]   <= pwdata;
        REG_END_Y:          end_r[1]   <= pwdata;
        REG_END_Z:          end_r[2]   <= pwdata;
        REG_SWING_DURATION: dur_r      <= pwdata[DUR_W-1:0];
        REG_BUMP_HEIGHT:    height_r   <= pwdata;
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (reg_idx_t'(paddr[ADDR_W-1:2]))
      REG_START_X:        prdata = start_r[0];
      REG_START_Y:        prdata = start_r[1];
      REG_START_Z:        prdata = start_r[2];
      REG_END_X:          prdata = end_r[0];
      REG_END_Y:          prdata = end_r[1];
      REG_END_Z:          prdata = end_r[2];
      REG_SWING_DURATION: prdata = {1'b0, dur_r};
      REG_BUMP_HEIGHT:    prdata = height_r;
      default:            prdata = '0;
    endcase
  end

  // Global advance: move when the output slot is free or being taken
  assign en       = !out_vld_r || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < TOT_LAT; k++) begin
        vld_r[k] <= 1'b0;
      end
      out_vld_r <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int k = 1; k < TOT_LAT; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
      out_vld_r <= vld_r[TOT_LAT-1];
    end
  end

  mjst_phase u_phase (
    .clk (clk),
    .en  (en),
    .t   (in_query_time),
    .dur (dur_r),
    .s   (phase_s)
  );

  mjst_poly u_poly (
    .clk (clk),
    .en  (en),
    .s   (phase_s),
    .bas (bas)
  );

  // Scale basis terms by travel and bump height
  always_comb begin
    for (int k = 0; k < AXES; k++) begin
      dp[k] = DP_W'(end_r[k]) - DP_W'(start_r[k]);
    end
    h = DP_W'(height_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < AXES; k++) begin
        pm_r[k] <= mulq(dp[k], bas.mj);
        vm_r[k] <= mulq(dp[k], bas.dmj);
        am_r[k] <= mulq(dp[k], bas.d2mj);
      end
      pm_r[LANE_BUMP] <= mulq(h, bas.b);
      vm_r[LANE_BUMP] <= mulq(h, bas.db);
      am_r[LANE_BUMP] <= mulq(h, bas.d2b);
    end
  end

  // Rate dividers: once for velocity, twice in series for acceleration
  for (genvar g = 0; g < NLANE; g++) begin : g_lane
    mjst_qdiv u_vdiv (
      .clk (clk),
      .en  (en),
      .dur (dur_r),
      .x   (vm_r[g]),
      .q   (vq[g])
    );

    mjst_qdiv u_adiv1 (
      .clk (clk),
      .en  (en),
      .dur (dur_r),
      .x   (am_r[g]),
      .q   (aq1[g])
    );

    assign aq1_w[g] = WIDE_W'(aq1[g]);

    mjst_qdiv u_adiv2 (
      .clk (clk),
      .en  (en),
      .dur (dur_r),
      .x   (aq1_w[g]),
      .q   (aq2[g])
    );
  end

  // Hold position and velocity terms until acceleration catches up
  always_ff @(posedge clk) begin
    if (en) begin
      for (int g = 0; g < NLANE; g++) begin
        pdly_r[g][0] <= pm_r[g];
        for (int i = 1; i < PD; i++) begin
          pdly_r[g][i] <= pdly_r[g][i-1];
        end
        vdly_r[g][0] <= vq[g];
        for (int i = 1; i < DIV_LAT; i++) begin
          vdly_r[g][i] <= vdly_r[g][i-1];
        end
      end
    end
  end

  // Sum per axis, bump on z
  always_comb begin
    for (int k = 0; k < AXES; k++) begin
      pos_sum[k] = WIDE_W'(start_r[k]) + pdly_r[k][PD-1];
      vel_sum[k] = WIDE_W'(vdly_r[k][DIV_LAT-1]);
      acc_sum[k] = WIDE_W'(aq2[k]);
      if (k == AXIS_Z) begin
        pos_sum[k] = pos_sum[k] + pdly_r[LANE_BUMP][PD-1];
        vel_sum[k] = vel_sum[k] + WIDE_W'(vdly_r[LANE_BUMP][DIV_LAT-1]);
        acc_sum[k] = acc_sum[k] + WIDE_W'(aq2[LANE_BUMP]);
      end
    end
  end

  // Output register; zero duration holds at the start point
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < AXES; k++) begin
        if (dur_r == '0) begin
          opos_r[k] <= start_r[k];
          ovel_r[k] <= '0;
          oacc_r[k] <= '0;
        end else begin
          opos_r[k] <= sat32(pos_sum[k]);
          ovel_r[k] <= sat32(vel_sum[k]);
          oacc_r[k] <= sat32(acc_sum[k]);
        end
      end
    end
  end

  assign out_valid = out_vld_r;
  assign out_pos_x = opos_r[0];
  assign out_pos_y = opos_r[1];
  assign out_pos_z = opos_r[2];
  assign out_vel_x = ovel_r[0];
  assign out_vel_y = ovel_r[1];
  assign out_vel_z = ovel_r[2];
  assign out_acc_x = oacc_r[0];
  assign out_acc_y = oacc_r[1];
  assign out_acc_z = oacc_r[2];

`ifndef SYNTHESIS
  a_reset_empties: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[TOT_LAT-1] && !en) |=> vld_r[TOT_LAT-1])
    else $error("last stage lost a transaction during stall");

  a_zero_dur_rates: assert property (@(posedge clk) disable iff (!rst_n)
    (en && vld_r[TOT_LAT-1] && dur_r == '0) |=> (out_vel_x == '0 && out_acc_z == '0))
    else $error("nonzero rate with zero duration");
`endif

endmodule
